FILE: src/sensor_link_health_watchdog_core_defines.svh
// Assertion macros shared by the watchdog RTL
`ifndef SENSOR_LINK_HEALTH_WATCHDOG_CORE_DEFINES_SVH
`define SENSOR_LINK_HEALTH_WATCHDOG_CORE_DEFINES_SVH

// Check a property while out of reset
`define SLHW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define SLHW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/slhw_pkg.sv
`default_nettype none
package slhw_pkg;

	localparam int TIME_BITS = 48;
	localparam int REG_W     = 48;
	localparam int CMP_W     = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
	localparam int IN_W      = ((TIME_BITS + 9 + 7) / 8) * 8;
	localparam int OUT_W     = 24;
	localparam int IDX_W     = 3;

	localparam logic OP_PET   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_COMM     = 2'd1;
	localparam logic [1:0] EV_MISMATCH = 2'd2;
	localparam logic [1:0] EV_NO_DATA  = 2'd3;

	localparam logic [IDX_W-1:0] REG_DATA_TIMEOUT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_PROBE_INTERVAL = 3'd1;
	localparam logic [IDX_W-1:0] REG_COMM_FAIL_LIM  = 3'd2;
	localparam logic [IDX_W-1:0] REG_NO_DATA_LIM    = 3'd3;
	localparam logic [IDX_W-1:0] REG_EXPECTED_ID    = 3'd4;

	localparam logic [REG_W-1:0] RST_DATA_TIMEOUT   = REG_W'(500000);
	localparam logic [REG_W-1:0] RST_PROBE_INTERVAL = REG_W'(1000000);
	localparam logic [7:0]       RST_COMM_FAIL_LIM  = 8'd3;
	localparam logic [7:0]       RST_NO_DATA_LIM    = 8'd3;
	localparam logic [7:0]       RST_EXPECTED_ID    = 8'd104;

	typedef struct packed {
		logic                 opcode;
		logic [TIME_BITS-1:0] now_time;
		logic                 probe_ok;
		logic [7:0]           probe_id;
	} item_t;

	typedef struct packed {
		logic [REG_W-1:0] data_timeout;
		logic [REG_W-1:0] probe_interval;
		logic [7:0]       comm_fail_limit;
		logic [7:0]       no_data_limit;
		logic [7:0]       expected_id;
	} cfg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] last_pet_time;
		logic [TIME_BITS-1:0] last_probe_time;
		logic [7:0]           fail_cnt;
		logic [7:0]           no_data_cnt;
		logic                 disconnected;
	} state_t;

	typedef struct packed {
		logic [7:0] stale_count;
		logic [7:0] fail_count;
		logic       disconnected;
		logic [1:0] error_event;
		logic       timed_out;
		logic       probe_used;
	} result_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage
`default_nettype wire

FILE: src/slhw_eval.sv
`default_nettype none
module slhw_eval
	import slhw_pkg::*;
(
	input  item_t   item,
	input  state_t  st,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	logic [TIME_BITS-1:0] since_pet;
	logic [TIME_BITS-1:0] since_probe;
	logic                 is_to;
	logic                 due;
	logic [7:0]           fail_inc;
	logic [7:0]           nd_inc;
	logic [1:0]           event_code;

	assign since_pet   = item.now_time - st.last_pet_time;
	assign since_probe = item.now_time - st.last_probe_time;
	assign is_to       = CMP_W'(since_pet) > CMP_W'(cfg.data_timeout);
	assign due         = CMP_W'(since_probe) > CMP_W'(cfg.probe_interval);
	assign fail_inc    = sat_inc(st.fail_cnt);
	assign nd_inc      = sat_inc(st.no_data_cnt);

	always_comb begin
		nxt        = st;
		event_code = EV_NONE;
		if (item.opcode == OP_PET) begin
			nxt.last_pet_time = item.now_time;
			nxt.no_data_cnt   = 8'd0;
		end else if (is_to || due) begin
			if (due) begin
				nxt.last_probe_time = item.now_time;
			end
			if (!item.probe_ok) begin
				nxt.no_data_cnt = 8'd0;
				if (fail_inc >= cfg.comm_fail_limit) begin
					event_code       = EV_COMM;
					nxt.fail_cnt     = 8'd0;
					nxt.disconnected = 1'b1;
				end else begin
					nxt.fail_cnt = fail_inc;
				end
			end else begin
				nxt.fail_cnt = 8'd0;
				if (item.probe_id != cfg.expected_id) begin
					event_code       = EV_MISMATCH;
					nxt.disconnected = 1'b1;
				end else begin
					nxt.disconnected = 1'b0;
					if (is_to) begin
						if (nd_inc >= cfg.no_data_limit) begin
							event_code      = EV_NO_DATA;
							nxt.no_data_cnt = 8'd0;
						end else begin
							nxt.no_data_cnt = nd_inc;
						end
					end else begin
						nxt.no_data_cnt = 8'd0;
					end
				end
			end
		end
	end

	always_comb begin
		res.probe_used   = (item.opcode == OP_CHECK) && (is_to || due);
		res.timed_out    = (item.opcode == OP_CHECK) && is_to;
		res.error_event  = event_code;
		res.disconnected = nxt.disconnected;
		res.fail_count   = nxt.fail_cnt;
		res.stale_count  = nxt.no_data_cnt;
	end

endmodule
`default_nettype wire

FILE: src/sensor_link_health_watchdog_core.sv
// Sensor link health watchdog.
// Requests enter on the s_* stream: s_tuser is the opcode (pet or health check),
// s_tdata carries the timestamp and the probe result. Every request yields
// exactly one result on the m_* stream with the error event and link status.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only while
// idle, which the block itself does not enforce; unknown indexes are ignored.
// A request passes through the input register, then the result register, before its result
// appears. Throughput: one request per cycle while the receiver does not stall; the
// state update for a request is combinational between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready drops until m_tready returns; nothing is lost.
// Reset (arst_n low) empties both registers, clears all timestamps and counters,
// clears the disconnected flag and loads the default configuration.
`default_nettype none
`include "sensor_link_health_watchdog_core_defines.svh"
module sensor_link_health_watchdog_core
	import slhw_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // now_time, probe_ok, probe_id, zero fill
	input  wire logic             s_tuser,  // opcode
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // probe_used, timed_out, error_event,
	                                        // disconnected, fail_count, stale_count, zero fill
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    vld_s1;
	result_t res_q;
	result_t res_nxt;
	logic    out_vld_q;
	logic    advance;

	assign advance  = !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || advance;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_W'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_timeout    <= RST_DATA_TIMEOUT;
			cfg_q.probe_interval  <= RST_PROBE_INTERVAL;
			cfg_q.comm_fail_limit <= RST_COMM_FAIL_LIM;
			cfg_q.no_data_limit   <= RST_NO_DATA_LIM;
			cfg_q.expected_id     <= RST_EXPECTED_ID;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DATA_TIMEOUT:   cfg_q.data_timeout    <= cfg_data;
				REG_PROBE_INTERVAL: cfg_q.probe_interval  <= cfg_data;
				REG_COMM_FAIL_LIM:  cfg_q.comm_fail_limit <= cfg_data[7:0];
				REG_NO_DATA_LIM:    cfg_q.no_data_limit   <= cfg_data[7:0];
				REG_EXPECTED_ID:    cfg_q.expected_id     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.opcode   <= s_tuser;
			item_s1.now_time <= s_tdata[TIME_BITS-1:0];
			item_s1.probe_ok <= s_tdata[TIME_BITS];
			item_s1.probe_id <= s_tdata[TIME_BITS+8:TIME_BITS+1];
		end
	end

	slhw_eval u_eval (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
			if (vld_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			res_q <= res_nxt;
		end
	end

	`SLHW_ASSERT(a_comm_disc, m_tvalid && res_q.error_event == EV_COMM |-> res_q.disconnected && res_q.fail_count == 8'd0, "comm error without disconnect or with live fail count")
	`SLHW_ASSERT(a_unused_quiet, m_tvalid && !res_q.probe_used |-> res_q.error_event == EV_NONE && !res_q.timed_out, "event or timeout on a request that used no probe")
	`SLHW_ASSERT(a_mismatch_disc, m_tvalid && res_q.error_event == EV_MISMATCH |-> res_q.disconnected && res_q.fail_count == 8'd0, "identity mismatch without disconnect")
	`SLHW_ASSERT(a_state_follows, m_tvalid && $rose(m_tvalid) |-> res_q.fail_count == state_q.fail_cnt && res_q.stale_count == state_q.no_data_cnt, "result status differs from stored state")
	`SLHW_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> !m_tvalid && !vld_s1, "pipeline not empty out of reset")

endmodule
`default_nettype wire
